// ----- rtl/blc_pkg.sv -----
// Shared types and constants for the Bayer black level correction block.
// No dependencies.
package blc_pkg;

  localparam int PIX_W       = 12;  // pixel port width
  localparam int SIZE_W      = 13;  // frame_width / frame_height
  localparam int GAIN_W      = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int COL_W       = 11;  // pair column counter
  localparam int ROW_W       = 12;  // row counter
  localparam int PROD_W      = PIX_W + GAIN_W;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH        = 3'd0,
    REG_FRAME_HEIGHT       = 3'd1,
    REG_BLACK_RED          = 3'd2,
    REG_BLACK_GREEN_RED    = 3'd3,
    REG_BLACK_GREEN_BLUE   = 3'd4,
    REG_BLACK_BLUE         = 3'd5,
    REG_RED_TO_GREEN_GAIN  = 3'd6,
    REG_BLUE_TO_GREEN_GAIN = 3'd7
  } blc_reg_t;

  // pair as registered at the input
  typedef struct packed {
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] right;
    logic             in_border;
    logic             odd_row;
  } blc_in_stage_t;

  // after black level subtraction and the gain multiply
  typedef struct packed {
    logic [PIX_W-1:0]  pass_left;
    logic [PIX_W-1:0]  pass_right;
    logic [PIX_W-1:0]  corr_color;  // corrected R (even row) or B (odd row)
    logic [PIX_W-1:0]  corr_green;  // corrected Gr or Gb
    logic [PROD_W-1:0] product;
    logic              in_border;
    logic              odd_row;
  } blc_mul_stage_t;

  function automatic logic [PIX_W-1:0] floor_sub(input logic [PIX_W-1:0] v,
                                                 input logic [PIX_W-1:0] bl);
    floor_sub = (v > bl) ? (v - bl) : '0;
  endfunction

endpackage

// ----- rtl/bayer_black_level_correction.sv -----
// Black level correction for an RGGB Bayer stream, one pixel pair per request.
// Depends on blc_pkg (widths, register indexes, stage structs, floor_sub).
//
//  channel | dir | handshake                 | payload
//  in      | in  | in_valid / in_ready       | pixel_left, pixel_right, frame_start
//  out     | out | out_valid / out_ready     | out_left, out_right
//  cfg     | in  | cfg_write (no wait)       | cfg_index, cfg_data
//
// One request per clock while out_ready is high; a request passes the input
// register, black subtract + gain multiply, add + saturate; then out_valid rises.
// Reset clears all stage valids and the position counters and loads the
// register defaults (1920 x 1080, zero black levels and gains).
// A low out_ready backs up stage by stage; a stage takes a new request when
// it is empty or its content moves on in the same cycle.
module bayer_black_level_correction #(
  parameter int PIXEL_BITS    = 12,
  parameter int FRACTION_BITS = 8,
  parameter int MAX_WIDTH     = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [blc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [blc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [blc_pkg::PIX_W-1:0]       pixel_left,
  input  logic [blc_pkg::PIX_W-1:0]       pixel_right,
  input  logic                            frame_start,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [blc_pkg::PIX_W-1:0]       out_left,
  output logic [blc_pkg::PIX_W-1:0]       out_right
);
  import blc_pkg::*;

  localparam int FULL_SCALE_INT = (PIXEL_BITS >= PIX_W) ? 4095 : (1 << PIXEL_BITS) - 1;
  localparam int PAIR_CAP_INT   = (MAX_WIDTH / 2 > 2048) ? 2048 : MAX_WIDTH / 2;
  localparam logic [PIX_W-1:0]  FULL_SCALE = FULL_SCALE_INT[PIX_W-1:0];
  localparam logic [ROW_W-1:0]  PAIR_CAP   = PAIR_CAP_INT[ROW_W-1:0];
  localparam logic [SIZE_W-1:0] ROW_CAP    = 13'd4096;

  // configuration registers
  logic [SIZE_W-1:0] frame_width, frame_height;
  logic [PIX_W-1:0]  black_red, black_green_red, black_green_blue, black_blue;
  logic [GAIN_W-1:0] red_to_green_gain, blue_to_green_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width        <= 13'd1920;
      frame_height       <= 13'd1080;
      black_red          <= '0;
      black_green_red    <= '0;
      black_green_blue   <= '0;
      black_blue         <= '0;
      red_to_green_gain  <= '0;
      blue_to_green_gain <= '0;
    end else if (cfg_write) begin
      unique case (blc_reg_t'(cfg_index))
        REG_FRAME_WIDTH:        frame_width        <= cfg_data[SIZE_W-1:0];
        REG_FRAME_HEIGHT:       frame_height       <= cfg_data[SIZE_W-1:0];
        REG_BLACK_RED:          black_red          <= cfg_data[PIX_W-1:0];
        REG_BLACK_GREEN_RED:    black_green_red    <= cfg_data[PIX_W-1:0];
        REG_BLACK_GREEN_BLUE:   black_green_blue   <= cfg_data[PIX_W-1:0];
        REG_BLACK_BLUE:         black_blue         <= cfg_data[PIX_W-1:0];
        REG_RED_TO_GREEN_GAIN:  red_to_green_gain  <= cfg_data[GAIN_W-1:0];
        REG_BLUE_TO_GREEN_GAIN: blue_to_green_gain <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic           s1_valid, s2_valid;
  logic           load1, load2, load3;
  logic           in_accept;
  blc_in_stage_t  s1, s1_next;
  blc_mul_stage_t s2, s2_next;

  assign load3     = !out_valid || out_ready;
  assign load2     = !s2_valid || load3;
  assign load1     = !s1_valid || load2;
  assign in_ready  = load1;
  assign in_accept = in_valid && in_ready;

  // position counters
  logic [COL_W-1:0]  pair_column, pair_column_next, col_now;
  logic [ROW_W-1:0]  row_index, row_index_next, row_now;
  logic [ROW_W-1:0]  pairs;
  logic [SIZE_W-1:0] rows;
  logic [SIZE_W-1:0] col_x2, row_even;
  logic              col_wrap, row_wrap;

  always_comb begin
    col_now = frame_start ? '0 : pair_column;
    row_now = frame_start ? '0 : row_index;

    pairs = frame_width[SIZE_W-1:1];
    if (pairs == '0) pairs = 12'd1;
    if (pairs > PAIR_CAP) pairs = PAIR_CAP;
    rows = frame_height;
    if (rows == '0) rows = 13'd1;
    if (rows > ROW_CAP) rows = ROW_CAP;

    col_wrap = ({1'b0, col_now} + 12'd1) >= pairs;
    row_wrap = ({1'b0, row_now} + 13'd1) >= rows;

    if (col_wrap) begin
      pair_column_next = '0;
      row_index_next   = row_wrap ? '0 : row_now + 12'd1;
    end else begin
      pair_column_next = col_now + 11'd1;
      row_index_next   = row_now;
    end

    // border test on the pair's left pixel column and the even row of its pair
    col_x2   = {1'b0, col_now, 1'b0};
    row_even = {1'b0, row_now[ROW_W-1:1], 1'b0};
    s1_next.left      = pixel_left;
    s1_next.right     = pixel_right;
    s1_next.odd_row   = row_now[0];
    s1_next.in_border = (col_x2 >= 13'd2) && (col_x2 + 13'd2 < frame_width) &&
                        (row_even >= 13'd2) && (row_even + 13'd2 < frame_height);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_column <= '0;
      row_index   <= '0;
    end else if (in_accept) begin
      pair_column <= pair_column_next;
      row_index   <= row_index_next;
    end
  end

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (load1) s1_valid <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (in_accept) s1 <= s1_next;
  end

  // stage 2: black level subtraction and gain multiply
  always_comb begin
    logic [PIX_W-1:0]  color;
    logic [GAIN_W-1:0] gain;
    if (s1.odd_row) begin
      color              = floor_sub(s1.right, black_blue);
      s2_next.corr_green = floor_sub(s1.left, black_green_blue);
      gain               = blue_to_green_gain;
    end else begin
      color              = floor_sub(s1.left, black_red);
      s2_next.corr_green = floor_sub(s1.right, black_green_red);
      gain               = red_to_green_gain;
    end
    s2_next.corr_color = color;
    s2_next.product    = color * gain;
    s2_next.pass_left  = s1.left;
    s2_next.pass_right = s1.right;
    s2_next.in_border  = s1.in_border;
    s2_next.odd_row    = s1.odd_row;
  end

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (load2) s2_valid <= s1_valid;
  end
  always_ff @(posedge clk) begin
    if (load2 && s1_valid) s2 <= s2_next;
  end

  // stage 3: add the scaled cross term, saturate, result register
  logic [PROD_W-1:0] delta;
  logic [PROD_W:0]   sum;
  logic [PIX_W-1:0]  green_sat;
  logic [PIX_W-1:0]  out_left_next, out_right_next;

  always_comb begin
    delta     = s2.product >> FRACTION_BITS;
    sum       = {1'b0, delta} + {{(PROD_W + 1 - PIX_W){1'b0}}, s2.corr_green};
    green_sat = (sum > {{(PROD_W + 1 - PIX_W){1'b0}}, FULL_SCALE}) ?
                FULL_SCALE : sum[PIX_W-1:0];
    if (!s2.in_border) begin
      out_left_next  = s2.pass_left;
      out_right_next = s2.pass_right;
    end else if (s2.odd_row) begin
      out_left_next  = green_sat;
      out_right_next = s2.corr_color;
    end else begin
      out_left_next  = s2.corr_color;
      out_right_next = green_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load3) out_valid <= s2_valid;
  end
  always_ff @(posedge clk) begin
    if (load3 && s2_valid) begin
      out_left  <= out_left_next;
      out_right <= out_right_next;
    end
  end

  // checks
  assert property (@(posedge clk) disable iff (rst)
    {1'b0, pair_column} < PAIR_CAP)
    else $error("pair column counter beyond row wrap limit");

  assert property (@(posedge clk) disable iff (rst)
    in_accept && frame_start |=> (pair_column == 11'd1 || pair_column == 11'd0))
    else $error("frame start did not restart the column count");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s2_valid))
    else $error("result appeared without a request in the multiply stage");

  assert property (@(posedge clk) disable iff (rst)
    s2_valid && !load3 |=> s2_valid && $stable(s2))
    else $error("multiply stage lost or changed a stalled request");

endmodule

// ----- test/bayer_black_level_correction_tb.sv -----
// Testbench for bayer_black_level_correction: streams Bayer pixel pairs and checks every result
// against a cycle-free predictor of the correction, with random idling on both channels.
// Depends on blc_pkg and the bayer_black_level_correction RTL.
module bayer_black_level_correction_tb;
  import blc_pkg::*;

  localparam int PIXEL_BITS    = 12;
  localparam int FRACTION_BITS = 8;
  localparam int MAX_WIDTH     = 4096;

  localparam int PIX_MAX       = (1 << PIX_W) - 1;
  localparam int FULL_SCALE    = ((1 << PIXEL_BITS) - 1 > 4095) ? 4095 : (1 << PIXEL_BITS) - 1;
  localparam int MAX_PAIRS     = (MAX_WIDTH / 2 > 2048) ? 2048 : MAX_WIDTH / 2;
  localparam int MAX_ROWS      = 4096;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 6;     // pipeline is 3 deep
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int WIDE_PAIRS    = 64;
  localparam int NUM_CORNERS   = 6;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] right;
  } pix_pair_t;

  localparam logic [PIX_W-1:0] DIR_LEFT [24] = '{
    0, 4095, 0, 4095, 2730, 1,      4095, 0, 1365, 2048, 4095, 0,
    4095, 50, 100, 4095, 500, 0,    0, 250, 4095, 300, 1000, 4095};
  localparam logic [PIX_W-1:0] DIR_RIGHT [24] = '{
    0, 4095, 4095, 0, 1365, 2048,   4095, 0, 2730, 1, 0, 4095,
    4095, 150, 200, 4095, 300, 0,   4095, 350, 4095, 401, 400, 4095};
  localparam logic [CFG_DATA_W-1:0] SIZE_CORNERS [NUM_CORNERS] = '{
    16'd0, 16'd1, 16'd7, 16'd6, 16'hFFFF, 16'd4096};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  blc_reg_t              cfg_index = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      pixel_left = '0;
  logic [PIX_W-1:0]      pixel_right = '0;
  logic                  frame_start = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_W-1:0]      out_left;
  logic [PIX_W-1:0]      out_right;

  // register mirror, reset values
  logic [SIZE_W-1:0] frame_w  = 13'd1920;
  logic [SIZE_W-1:0] frame_h  = 13'd1080;
  logic [PIX_W-1:0]  black_r  = '0;
  logic [PIX_W-1:0]  black_gr = '0;
  logic [PIX_W-1:0]  black_gb = '0;
  logic [PIX_W-1:0]  black_b  = '0;
  logic [GAIN_W-1:0] gain_rg  = '0;
  logic [GAIN_W-1:0] gain_bg  = '0;

  logic [COL_W-1:0] col_pos = '0;
  logic [ROW_W-1:0] row_pos = '0;

  pix_pair_t expected_pairs[$];

  int gap_pct = 0;
  int stall_pct = 0;
  int hold_token = 0;
  int hold_served = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int pairs_sent = 0;
  int inside_pairs = 0;
  int results_checked = 0;
  int reg_writes = 0;
  int mismatches = 0;

  bayer_black_level_correction #(
    .PIXEL_BITS   (PIXEL_BITS),
    .FRACTION_BITS(FRACTION_BITS),
    .MAX_WIDTH    (MAX_WIDTH)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel_left (pixel_left),
    .pixel_right(pixel_right),
    .frame_start(frame_start),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_left   (out_left),
    .out_right  (out_right)
  );

  always #2 clk = ~clk;

  function automatic logic [PIX_W-1:0] minus_black(input logic [PIX_W-1:0] v,
                                                   input logic [PIX_W-1:0] lvl);
    return (v > lvl) ? v - lvl : '0;
  endfunction

  function automatic int pairs_per_row();
    int p;
    p = frame_w >> 1;
    if (p < 1) p = 1;
    if (p > MAX_PAIRS) p = MAX_PAIRS;
    return p;
  endfunction

  function automatic int rows_per_frame();
    int r;
    r = frame_h;
    if (r < 1) r = 1;
    if (r > MAX_ROWS) r = MAX_ROWS;
    return r;
  endfunction

  // Expected output for one accepted request; advances the raster position.
  function automatic void predict_pair(input logic [PIX_W-1:0] l, input logic [PIX_W-1:0] r,
                                       input logic fs);
    int unsigned j;
    int unsigned i;
    longint unsigned color;
    longint unsigned green;
    longint unsigned sum;
    pix_pair_t res;
    if (fs) begin
      col_pos = '0;
      row_pos = '0;
    end
    j = 2 * col_pos;
    i = {row_pos[ROW_W-1:1], 1'b0};
    res.left = l;
    res.right = r;
    if (j >= 2 && j + 2 < frame_w && i >= 2 && i + 2 < frame_h) begin
      inside_pairs++;
      if (!row_pos[0]) begin
        color = minus_black(l, black_r);
        green = minus_black(r, black_gr);
        sum = green + ((color * gain_rg) >> FRACTION_BITS);
        res.left = color;
        res.right = (sum > FULL_SCALE) ? FULL_SCALE : sum;
      end else begin
        color = minus_black(r, black_b);
        green = minus_black(l, black_gb);
        sum = green + ((color * gain_bg) >> FRACTION_BITS);
        res.left = (sum > FULL_SCALE) ? FULL_SCALE : sum;
        res.right = color;
      end
    end
    expected_pairs.push_back(res);
    if (col_pos + 1 >= pairs_per_row()) begin
      col_pos = '0;
      if (row_pos + 1 >= rows_per_frame()) row_pos = '0;
      else row_pos = row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [PIX_W-1:0] want_v,
                                 input logic [PIX_W-1:0] got_v);
    mismatches++;
    if (mismatches <= 30)
      $display("[%0t] MISMATCH %s: expected %0d, got %0d (result %0d)",
               $time, what, want_v, got_v, results_checked);
  endtask

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        gap_pct = 0;
        stall_pct = 0;
      end
      IDLE_SEND: begin
        gap_pct = 62;
        stall_pct = 0;
      end
      IDLE_RECV: begin
        gap_pct = 0;
        stall_pct = 62;
      end
      default: begin
        gap_pct = 14;
        stall_pct = 14;
      end
    endcase
  endtask

  // valid is only lowered for a gap, so back-to-back requests keep it high
  task automatic send_pair(input logic [PIX_W-1:0] l, input logic [PIX_W-1:0] r,
                           input logic fs);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < gap_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_left <= l;
    pixel_right <= r;
    frame_start <= fs;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    predict_pair(l, r, fs);
    pairs_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input blc_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_FRAME_WIDTH:        frame_w = data[SIZE_W-1:0];
      REG_FRAME_HEIGHT:       frame_h = data[SIZE_W-1:0];
      REG_BLACK_RED:          black_r = data[PIX_W-1:0];
      REG_BLACK_GREEN_RED:    black_gr = data[PIX_W-1:0];
      REG_BLACK_GREEN_BLUE:   black_gb = data[PIX_W-1:0];
      REG_BLACK_BLUE:         black_b = data[PIX_W-1:0];
      REG_RED_TO_GREEN_GAIN:  gain_rg = data;
      REG_BLUE_TO_GREEN_GAIN: gain_bg = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic configure(input logic [15:0] w, input logic [15:0] h,
                           input logic [15:0] br, input logic [15:0] bgr,
                           input logic [15:0] bgb, input logic [15:0] bb,
                           input logic [15:0] grg, input logic [15:0] gbg);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_BLACK_RED, br);
    write_reg(REG_BLACK_GREEN_RED, bgr);
    write_reg(REG_BLACK_GREEN_BLUE, bgb);
    write_reg(REG_BLACK_BLUE, bb);
    write_reg(REG_RED_TO_GREEN_GAIN, grg);
    write_reg(REG_BLUE_TO_GREEN_GAIN, gbg);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // upper bits beyond the register width are set now and then; they must be dropped
  function automatic logic [15:0] rand_black();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'(PIX_MAX);
      2: return 16'($urandom_range(255));
      3: return 16'($urandom_range(65535));
      default: return 16'($urandom_range(PIX_MAX));
    endcase
  endfunction

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd1 << FRACTION_BITS;  // unity
      3: return 16'($urandom_range(1023));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // mostly random, often right around the black level of its channel
  function automatic logic [PIX_W-1:0] pick_pixel(input logic [PIX_W-1:0] lvl);
    int v;
    case ($urandom_range(7))
      0: v = 0;
      1: v = PIX_MAX;
      2, 3: begin
        v = int'(lvl) + int'($urandom_range(6)) - 3;
        if (v < 0) v = 0;
        if (v > PIX_MAX) v = PIX_MAX;
      end
      default: v = $urandom_range(PIX_MAX);
    endcase
    return v[PIX_W-1:0];
  endfunction

  task automatic random_config(input int flavor);
    logic [15:0] w;
    logic [15:0] h;
    case ($urandom_range(5))
      0: w = 16'($urandom_range(24));
      1: w = 16'(2 * $urandom_range(3, 12)) | 16'($urandom_range(1, 7) << SIZE_W);
      default: w = 16'(2 * $urandom_range(3, 12));
    endcase
    case ($urandom_range(5))
      0: h = 16'($urandom_range(16));
      1: h = 16'(2 * $urandom_range(3, 7)) | 16'($urandom_range(1, 7) << SIZE_W);
      default: h = 16'(2 * $urandom_range(3, 7));
    endcase
    case (flavor)
      1: configure(w, h, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
      2: configure(w, h, 16'(PIX_MAX), 16'(PIX_MAX), 16'(PIX_MAX), 16'(PIX_MAX), 16'd0, 16'd0);
      default: configure(w, h, rand_black(), rand_black(), rand_black(), rand_black(),
                         rand_gain(), rand_gain());
    endcase
  endtask

  // Whole frames mostly; some cut short, and a stray frame_start now and then.
  task automatic send_frames(input int budget);
    int done;
    int n;
    done = 0;
    while (done < budget) begin
      n = pairs_per_row() * rows_per_frame();
      if ($urandom_range(4) == 0) n = $urandom_range(1, n);
      for (int k = 0; k < n; k++) begin
        send_pair(pick_pixel(row_pos[0] ? black_gb : black_r),
                  pick_pixel(row_pos[0] ? black_b : black_gr),
                  k == 0 || $urandom_range(59) == 0);
        done++;
      end
    end
  endtask

  task automatic test_reset_defaults();
    set_idle(IDLE_NONE);
    send_pair(12'd0, 12'd0, 1'b0);
    send_pair(12'hFFF, 12'hFFF, 1'b0);
    send_pair(12'hAAA, 12'h555, 1'b0);
    send_pair(12'h555, 12'hAAA, 1'b1);
    send_pair(12'hFFF, 12'h000, 1'b0);
    wait_idle();
  endtask

  // 12 x 6 frame: rows 2 and 3, pairs 1..4 are inside. Floor, equal-to-black,
  // saturation and a full-width gain product on both row types.
  task automatic test_directed_corrections();
    configure(16'd12, 16'd6, 16'd100, 16'd200, 16'd300, 16'd400, 16'h0180, 16'hFFFF);
    for (int k = 0; k < 24; k++) send_pair(DIR_LEFT[k], DIR_RIGHT[k], k == 0);
    wait_idle();
  endtask

  // degenerate, odd and oversized frame sizes
  task automatic test_size_corners();
    int n;
    set_idle(IDLE_BOTH);
    for (int c = 0; c < NUM_CORNERS; c++) begin
      configure(SIZE_CORNERS[c], SIZE_CORNERS[c], rand_black(), rand_black(), rand_black(),
                rand_black(), rand_gain(), rand_gain());
      n = pairs_per_row() * rows_per_frame();
      n = (n <= 64) ? 2 * n : 40;
      for (int k = 0; k < n; k++)
        send_pair(12'($urandom_range(PIX_MAX)), 12'($urandom_range(PIX_MAX)), k == 0);
      wait_idle();
    end
  endtask

  // widest rows: wide column counter, the first row passes through unchanged
  task automatic test_widest_rows();
    set_idle(IDLE_NONE);
    configure(16'd4096, 16'd6, rand_black(), rand_black(), rand_black(), rand_black(),
              rand_gain(), rand_gain());
    for (int k = 0; k < WIDE_PAIRS; k++)
      send_pair(pick_pixel(row_pos[0] ? black_gb : black_r),
                pick_pixel(row_pos[0] ? black_b : black_gr), k == 0);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    idle_mode_t modes[4];
    modes = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};
    foreach (modes[m]) begin
      set_idle(modes[m]);
      for (int k = 0; k < 2; k++) begin
        random_config((k == 0 && m < 2) ? m + 1 : 0);
        send_frames(72);
        wait_idle();
      end
    end
  endtask

  // receiver holds off long enough for the pipeline to fill and drop in_ready
  task automatic test_output_backpressure();
    set_idle(IDLE_NONE);
    random_config(0);
    hold_token++;
    send_frames(96);
    wait_idle();
  endtask

  always @(posedge clk) begin : result_side
    pix_pair_t want;
    if (hold_token != hold_served) begin
      hold_served <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (expected_pairs.size() == 0) begin
        report_mismatch("result with no request pending", 'x, out_left);
      end else begin
        want = expected_pairs.pop_front();
        results_checked++;
        if (out_left !== want.left) report_mismatch("out_left", want.left, out_left);
        if (out_right !== want.right) report_mismatch("out_right", want.right, out_right);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[%0t] no request moved for %0d cycles", $time, idle_cycles);
      $display("bayer_black_level_correction_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed_corrections();
    test_size_corners();
    test_widest_rows();
    test_random_traffic();
    test_output_backpressure();
    wait_idle();
    $display("Sent %0d pixel pairs (%0d inside the border), %0d register writes, %0d checked,",
             pairs_sent, inside_pairs, reg_writes, results_checked);
    $display("sizes from degenerate to 4096 wide, all idle patterns, one long stall; %0d bad.",
             mismatches);
    if (mismatches == 0)
      $display("bayer_black_level_correction_tb: PASS");
    else
      $display("bayer_black_level_correction_tb: FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/blc_pkg.sv
rtl/bayer_black_level_correction.sv
test/bayer_black_level_correction_tb.sv
